@@ rtl/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the bilinear grayscale downscaler: request
// and result layouts, register indexes, neighbour codes and sequencer states.
// ----------------------------------------------------------------------------
package bgd_pkg;

	// Fixed field widths.
	localparam int REG_W     = 9;
	localparam int COORD_W   = 8;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Defaults for the top-level parameters.
	localparam int MAX_SRC_WIDTH_DEF  = 256;
	localparam int MAX_SRC_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF      = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

	// Request actions.
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Neighbour codes, in the order they are read.
	localparam logic [1:0] NB_TL = 2'd0;
	localparam logic [1:0] NB_TR = 2'd1;
	localparam logic [1:0] NB_BL = 2'd2;
	localparam logic [1:0] NB_BR = 2'd3;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   pixel;
	} bgd_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             bad_coord;
	} bgd_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} bgd_state_t;

endpackage

@@ rtl/bgd_ram.sv @@
// ----------------------------------------------------------------------------
// bgd_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read before write: a write cycle returns the old contents, and the read
	// data is registered before it reaches rdata.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/bgd_div.sv @@
// ----------------------------------------------------------------------------
// bgd_div
// Restoring divider, one quotient bit per cycle, that turns a source and a
// destination size into a fixed-point step (src << FRAC_BITS) / dst.
// ----------------------------------------------------------------------------
module bgd_div #(
	parameter int FRAC_BITS = bgd_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [bgd_pkg::REG_W-1:0]            src,
	input  logic [bgd_pkg::REG_W-1:0]            dst,
	output logic                                 busy,
	output logic [bgd_pkg::REG_W+FRAC_BITS-1:0]  step
);
	import bgd_pkg::*;

	localparam int N_W   = REG_W + FRAC_BITS;
	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   num_q;
	logic [N_W-1:0]   quot_q;
	logic [REG_W-1:0] rem_q;
	logic [REG_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REG_W:0]   trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign trial = {rem_q, num_q[N_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			quot_q <= '0;
		end else if (start) begin
			// A zero divisor gives a zero step and no iteration.
			quot_q <= '0;
			if (dst == '0) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= CNT_W'(N_W);
			end
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			quot_q <= {quot_q[N_W-2:0], fits};
		end
	end

	// Operand and remainder registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {src, FRAC_BITS'(0)};
			den_q <= dst;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[N_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= REG_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[REG_W-1:0];
			end
		end
	end

	assign busy = cnt_q != '0;
	assign step = quot_q;

endmodule

@@ rtl/bilinear_gray_downscale.sv @@
// ----------------------------------------------------------------------------
// bilinear_gray_downscale
// Grayscale downscaler with fixed-point bilinear interpolation over an
// on-chip image store.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on req (valid/ready). A load request writes one
// source pixel into the image store when its coordinate lies inside the
// store and leaves the block idle; it produces no result. A sample request
// produces one result on res (valid/ready): the interpolated gray value and
// a flag for a coordinate beyond the destination size. An in-range sample
// occupies the block from request to the next request: the accepting cycle,
// position and weight arithmetic, four reads of the single store port (one
// per neighbour), draining the multiply pipeline, handing the result over
// and the return to idle. A flagged sample, or one with a zero source size,
// skips straight from acceptance to the hand-over. Register writes on the
// cfg port take effect at the write edge and start the step dividers;
// req_ready is low in the write cycle, in the cycle that starts the dividers
// and while either divider is busy. Reset clears the registers to a 0 x 0
// source and a 1 x 1 destination; the image store is not cleared and must be
// loaded before it is sampled. A result waiting on res does not block further
// requests: a new sample runs to completion and then waits until the receiver
// takes the old one.
// ----------------------------------------------------------------------------
module bilinear_gray_downscale #(
	parameter int MAX_SRC_WIDTH  = bgd_pkg::MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = bgd_pkg::MAX_SRC_HEIGHT_DEF,
	parameter int FRAC_BITS      = bgd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  bgd_pkg::bgd_req_t             req,
	output logic                          res_valid,
	input  logic                          res_ready,
	output bgd_pkg::bgd_res_t             res,
	input  logic                          cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgd_pkg::REG_W-1:0]     cfg_wdata
);
	import bgd_pkg::*;

	localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW     = $clog2(DEPTH);
	localparam int STEP_W = REG_W + FRAC_BITS;
	localparam int PX_W   = COORD_W + STEP_W;
	localparam int INT_W  = PX_W - FRAC_BITS;
	localparam int G_W    = FRAC_BITS + 1;
	localparam int W_W    = 2 * G_W;
	localparam int ACC_W  = 2 * FRAC_BITS + 10;

	// Configuration registers.
	logic [REG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic             start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= '0;
			src_height_q <= '0;
			dst_width_q  <= REG_W'(1);
			dst_height_q <= REG_W'(1);
			start_q      <= 1'b0;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_WIDTH:  src_width_q  <= cfg_wdata;
					REG_SRC_HEIGHT: src_height_q <= cfg_wdata;
					REG_DST_WIDTH:  dst_width_q  <= cfg_wdata;
					REG_DST_HEIGHT: dst_height_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// Source sizes saturated to the store dimensions.
	logic [REG_W-1:0] sw, sh;

	assign sw = (32'(src_width_q) > MAX_SRC_WIDTH) ? REG_W'(MAX_SRC_WIDTH) : src_width_q;
	assign sh = (32'(src_height_q) > MAX_SRC_HEIGHT) ? REG_W'(MAX_SRC_HEIGHT) : src_height_q;

	// Step dividers, restarted by every register write.
	logic              busy_x, busy_y;
	logic [STEP_W-1:0] step_x, step_y;

	bgd_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.src    (sw),
		.dst    (dst_width_q),
		.busy   (busy_x),
		.step   (step_x)
	);

	bgd_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.src    (sh),
		.dst    (dst_height_q),
		.busy   (busy_y),
		.step   (step_y)
	);

	// Request classification.
	bgd_state_t state_q, state_d;
	logic       req_acc, is_load, is_bad, is_zero, load_ok;

	assign req_ready = (state_q == ST_IDLE) && !start_q && !busy_x && !busy_y && !cfg_we;
	assign req_acc   = req_valid && req_ready;
	assign is_load   = req.action == ACT_LOAD;
	assign is_bad    = ({1'b0, req.col} >= dst_width_q) || ({1'b0, req.row} >= dst_height_q);
	assign is_zero   = (src_width_q == '0) || (src_height_q == '0);
	assign load_ok   = (32'(req.col) < MAX_SRC_WIDTH) && (32'(req.row) < MAX_SRC_HEIGHT);

	// Pipeline bookkeeping for the neighbour reads.
	logic [1:0] nb_q;
	logic       v_s1, v_s2;
	logic       issue;

	assign issue = state_q == ST_READ;

	// Result hand-over condition.
	logic out_free;

	assign out_free = !res_valid || res_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic of the sample sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && !is_load) begin
					if (is_bad || is_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL:  state_d = ST_ADDR;
			ST_ADDR: state_d = ST_READ;
			ST_READ: begin
				if (nb_q == NB_BR) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sample position: destination coordinate times step.
	logic [COORD_W-1:0] col_q, row_q;
	logic [PX_W-1:0]    px_q, py_q;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			col_q <= req.col;
			row_q <= req.row;
		end
		if (state_q == ST_MUL) begin
			px_q <= PX_W'(col_q) * PX_W'(step_x);
			py_q <= PX_W'(row_q) * PX_W'(step_y);
		end
	end

	// Neighbour coordinates, clamped to the last column and row, and weights.
	logic [INT_W-1:0]     ix, iy;
	logic [REG_W-1:0]     x0, y0, x1, y1;
	logic [FRAC_BITS-1:0] fx, fy;
	logic [REG_W-1:0]     x0_q, y0_q, x1_q, y1_q;
	logic [G_W-1:0]       fx_q, fy_q, gx_q, gy_q;

	assign ix = px_q[PX_W-1:FRAC_BITS];
	assign iy = py_q[PX_W-1:FRAC_BITS];
	assign fx = px_q[FRAC_BITS-1:0];
	assign fy = py_q[FRAC_BITS-1:0];

	always_comb begin
		x0 = (ix >= INT_W'(sw)) ? REG_W'(sw - 1'b1) : ix[REG_W-1:0];
		y0 = (iy >= INT_W'(sh)) ? REG_W'(sh - 1'b1) : iy[REG_W-1:0];
		x1 = ((REG_W+1)'(x0) + 1'b1 < (REG_W+1)'(sw)) ? REG_W'(x0 + 1'b1)
		                                                : REG_W'(sw - 1'b1);
		y1 = ((REG_W+1)'(y0) + 1'b1 < (REG_W+1)'(sh)) ? REG_W'(y0 + 1'b1)
		                                                : REG_W'(sh - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			x0_q <= x0;
			y0_q <= y0;
			x1_q <= x1;
			y1_q <= y1;
			fx_q <= G_W'(fx);
			fy_q <= G_W'(fy);
			gx_q <= G_W'((G_W'(1) << FRAC_BITS) - G_W'(fx));
			gy_q <= G_W'((G_W'(1) << FRAC_BITS) - G_W'(fy));
		end
	end

	// Per-neighbour read address and weight operands.
	logic [REG_W-1:0] rx, ry;
	logic [G_W-1:0]   wa, wb;

	always_comb begin
		case (nb_q)
			NB_TL: begin
				rx = x0_q; ry = y0_q; wa = gx_q; wb = gy_q;
			end
			NB_TR: begin
				rx = x1_q; ry = y0_q; wa = fx_q; wb = gy_q;
			end
			NB_BL: begin
				rx = x0_q; ry = y1_q; wa = gx_q; wb = fy_q;
			end
			NB_BR: begin
				rx = x1_q; ry = y1_q; wa = fx_q; wb = fy_q;
			end
			default: begin
				rx = x0_q; ry = y0_q; wa = gx_q; wb = gy_q;
			end
		endcase
	end

	// Image store port: neighbour reads during a sample, writes on load.
	logic [AW-1:0]    mem_addr, rd_addr, ld_addr;
	logic             mem_we;
	logic [PIX_W-1:0] mem_rdata;

	assign rd_addr  = AW'(AW'(ry) * AW'(MAX_SRC_WIDTH)) + AW'(rx);
	assign ld_addr  = AW'(AW'(req.row) * AW'(MAX_SRC_WIDTH)) + AW'(req.col);
	assign mem_addr = issue ? rd_addr : ld_addr;
	assign mem_we   = req_acc && is_load && load_ok;

	bgd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (req.pixel),
		.rdata (mem_rdata)
	);

	// Read pipeline control: neighbour counter and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= NB_TL;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) begin
				nb_q <= nb_q + 1'b1;
			end else begin
				nb_q <= NB_TL;
			end
		end
	end

	// Weight, pixel product and accumulation, one register after each step.
	logic [W_W-1:0]   w_s1;
	logic [ACC_W-1:0] prod_s2;
	logic [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		w_s1    <= W_W'(wa) * W_W'(wb);
		prod_s2 <= ACC_W'(mem_rdata) * ACC_W'(w_s1);
		if (state_q == ST_ADDR) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Pending result, filled by the short cases at request time or by the
	// accumulator once the pipeline has drained.
	bgd_res_t res_q;

	always_ff @(posedge clk) begin
		if (req_acc && !is_load) begin
			res_q.value     <= '0;
			res_q.bad_coord <= is_bad;
		end else if (state_q == ST_DRAIN && !v_s1 && !v_s2) begin
			res_q.value     <= acc_q[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
			res_q.bad_coord <= 1'b0;
		end
	end

	// Output register.
	logic     res_valid_q;
	bgd_res_t res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_data_q <= res_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_data_q;

endmodule

@@ dv/bilinear_gray_downscale_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_gray_downscale_tb
// Self-checking bench for the bilinear grayscale downscaler. A behavioural
// predictor keeps its own copy of the image store and the geometry registers
// and works out every sample result as each request is accepted. A checker
// compares the results in order. Directed tests cover the edge and saturation
// cases, then randomised phases run varied geometries with bursty requests and
// a stalling receiver.
// ----------------------------------------------------------------------------
module bilinear_gray_downscale_tb;
	import bgd_pkg::*;

	localparam int          SRC_MAX  = MAX_SRC_WIDTH_DEF;
	localparam int          FRAC     = FRAC_BITS_DEF;
	localparam longint unsigned FRAC_ONE = 64'd1 << FRAC;
	localparam int          SETTLE   = 40;
	localparam int          LIMIT    = 1000000;
	localparam int          PHASES   = 12;
	localparam int          PHASE_ITEMS = 117;

	// Receiver behaviours.
	localparam int RDY_ALWAYS = 0;
	localparam int RDY_HALF   = 1;
	localparam int RDY_RARE   = 2;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	bgd_req_t          req       = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	bgd_res_t          res;
	logic              cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]  cfg_wdata = '0;

	// Predictor state: geometry registers and the image store.
	logic [REG_W-1:0]  src_w = 9'd0;
	logic [REG_W-1:0]  src_h = 9'd0;
	logic [REG_W-1:0]  dst_w = 9'd1;
	logic [REG_W-1:0]  dst_h = 9'd1;
	logic [PIX_W-1:0]  img_model [0:SRC_MAX*SRC_MAX-1];
	bit                img_written [0:SRC_MAX*SRC_MAX-1];

	bgd_res_t          pending_results [$];
	int                fail_count  = 0;
	int                cycle_count = 0;
	int                items_sent  = 0;
	int                burst_left  = 0;
	bit                pace_on     = 1'b0;
	int                hold_off_len = 0;
	int                ready_mode  = RDY_ALWAYS;
	int                mode_left   = 0;

	bilinear_gray_downscale dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: a long hold-off when a test asks for one, otherwise a random
	// pattern (always, half or rarely ready) that is picked anew as each run ends.
	always @(posedge clk) begin : ready_pattern
		if (hold_off_len != 0) begin
			res_ready <= 1'b0;
			hold_off_len = hold_off_len - 1;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(RDY_ALWAYS, RDY_RARE);
				mode_left  = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				RDY_ALWAYS: res_ready <= 1'b1;
				RDY_HALF:   res_ready <= 1'($urandom_range(0, 1));
				default:    res_ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Result checker: each accepted result against the oldest prediction.
	always @(posedge clk) begin : result_check
		bgd_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result: value %0d bad_coord %0b",
						res.value, res.bad_coord);
			end else begin
				want = pending_results.pop_front();
				if (res.value !== want.value || res.bad_coord !== want.bad_coord) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mismatch: expected value %0d bad_coord %0b,",
							want.value, want.bad_coord,
							" got value %0d bad_coord %0b",
							res.value, res.bad_coord);
				end
			end
		end
	end

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic longint unsigned pixel_at(input int unsigned x, input int unsigned y);
		return img_model[y * SRC_MAX + x];
	endfunction

	// Source position of a destination pixel: the four neighbour coordinates
	// and the fractional weights.
	function automatic void locate(input int unsigned col, input int unsigned row,
		output int unsigned x0, output int unsigned x1,
		output int unsigned y0, output int unsigned y1,
		output longint unsigned fx, output longint unsigned fy);
		int unsigned     sw;
		int unsigned     sh;
		longint unsigned stx;
		longint unsigned sty;
		longint unsigned px;
		longint unsigned py;
		longint unsigned ix;
		longint unsigned iy;
		sw  = clamp_size(src_w, SRC_MAX);
		sh  = clamp_size(src_h, SRC_MAX);
		stx = 64'(sw);
		sty = 64'(sh);
		stx = (dst_w == 0) ? 0 : (stx << FRAC) / dst_w;
		sty = (dst_h == 0) ? 0 : (sty << FRAC) / dst_h;
		px  = col * stx;
		py  = row * sty;
		ix  = px >> FRAC;
		iy  = py >> FRAC;
		x0  = (ix >= sw) ? sw - 1 : int'(ix);
		y0  = (iy >= sh) ? sh - 1 : int'(iy);
		x1  = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
		y1  = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
		fx  = px & (FRAC_ONE - 1);
		fy  = py & (FRAC_ONE - 1);
	endfunction

	// Expected result of a sample request under the current geometry.
	function automatic bgd_res_t predict_result(input int unsigned col, input int unsigned row);
		bgd_res_t        r;
		int unsigned     x0;
		int unsigned     x1;
		int unsigned     y0;
		int unsigned     y1;
		longint unsigned fx;
		longint unsigned fy;
		longint unsigned gx;
		longint unsigned gy;
		longint unsigned acc;
		r = '0;
		if (col >= dst_w || row >= dst_h) begin
			r.bad_coord = 1'b1;
			return r;
		end
		if (src_w == 0 || src_h == 0)
			return r;
		locate(col, row, x0, x1, y0, y1, fx, fy);
		gx  = FRAC_ONE - fx;
		gy  = FRAC_ONE - fy;
		acc = pixel_at(x0, y0) * gx * gy + pixel_at(x1, y0) * fx * gy
			+ pixel_at(x0, y1) * gx * fy + pixel_at(x1, y1) * fx * fy;
		r.value = PIX_W'(acc >> (2 * FRAC));
		return r;
	endfunction

	// Offer one request and hold it until accepted; valid is left high so
	// that a following request can go straight out.
	task automatic send_item(input bgd_req_t item);
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (item.action == ACT_LOAD) begin
			img_model[item.row * SRC_MAX + item.col]   = item.pixel;
			img_written[item.row * SRC_MAX + item.col] = 1'b1;
		end else begin
			pending_results.push_back(predict_result(item.col, item.row));
		end
	endtask

	// Send a request, then possibly end the burst with a random gap.
	task automatic push_request(input bgd_req_t item);
		send_item(item);
		items_sent++;
		if (pace_on) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic push_load(input int unsigned col, input int unsigned row,
		input int unsigned pix);
		bgd_req_t item;
		item.action = ACT_LOAD;
		item.col    = COORD_W'(col);
		item.row    = COORD_W'(row);
		item.pixel  = PIX_W'(pix);
		push_request(item);
	endtask

	// Load any neighbour of an in-range sample that has never been written,
	// so the block never reads an undefined store entry.
	task automatic ensure_neighbours(input int unsigned col, input int unsigned row);
		int unsigned     x0;
		int unsigned     x1;
		int unsigned     y0;
		int unsigned     y1;
		longint unsigned fx;
		longint unsigned fy;
		int unsigned     xs [4];
		int unsigned     ys [4];
		if (col >= dst_w || row >= dst_h || src_w == 0 || src_h == 0)
			return;
		locate(col, row, x0, x1, y0, y1, fx, fy);
		xs = '{x0, x1, x0, x1};
		ys = '{y0, y0, y1, y1};
		foreach (xs[i]) begin
			if (!img_written[ys[i] * SRC_MAX + xs[i]])
				push_load(xs[i], ys[i], $urandom_range(0, 255));
		end
	endtask

	task automatic push_sample(input int unsigned col, input int unsigned row);
		bgd_req_t item;
		ensure_neighbours(col, row);
		item.action = ACT_SAMPLE;
		item.col    = COORD_W'(col);
		item.row    = COORD_W'(row);
		item.pixel  = PIX_W'($urandom_range(0, 255));
		push_request(item);
	endtask

	// Stop offering, wait for every outstanding result, then let the block
	// finish any load still in flight.
	task automatic go_quiet();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		go_quiet();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[REG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:  src_w = val[REG_W-1:0];
			REG_SRC_HEIGHT: src_h = val[REG_W-1:0];
			REG_DST_WIDTH:  dst_w = val[REG_W-1:0];
			default:        dst_h = val[REG_W-1:0];
		endcase
	endtask

	task automatic set_geometry(input int unsigned sw, input int unsigned sh,
		input int unsigned dw, input int unsigned dh);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
	endtask

	// Mostly small sizes, with zero, the maximum and oversize values mixed in.
	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 78)
			return $urandom_range(1, 16);
		if (r < 83)
			return 0;
		if (r < 90)
			return SRC_MAX;
		if (r < 95)
			return $urandom_range(SRC_MAX + 1, 511);
		return $urandom_range(17, SRC_MAX - 1);
	endfunction

	// Registers straight after reset: empty source, 1 x 1 destination.
	task automatic test_reset_state();
		push_sample(0, 0);
		push_sample(1, 0);
		push_sample(0, 255);
	endtask

	// Unit step on a 2 x 2 source: the right and bottom neighbours clamp.
	task automatic test_edge_clamping();
		set_geometry(2, 2, 2, 2);
		push_load(0, 0, 0);
		push_load(1, 0, 255);
		push_load(0, 1, 8'hAA);
		push_load(1, 1, 8'h55);
		push_sample(0, 0);
		push_sample(1, 1);
		push_sample(2, 0);
		push_sample(0, 2);
		push_sample(255, 255);
	endtask

	// A step of one and a half, giving half-weighted neighbours.
	task automatic test_fractional_step();
		set_geometry(3, 3, 2, 2);
		push_load(255, 255, 255);
		push_sample(1, 1);
		push_sample(1, 0);
	endtask

	// An empty source axis gives zero unless the coordinate is out of range.
	task automatic test_zero_source();
		set_geometry(0, 4, 4, 4);
		push_sample(1, 1);
		push_sample(4, 1);
		write_reg(REG_SRC_WIDTH, 4);
		write_reg(REG_SRC_HEIGHT, 0);
		push_sample(3, 3);
	endtask

	// A zero destination flags every sample.
	task automatic test_zero_destination();
		set_geometry(4, 4, 0, 0);
		push_sample(0, 0);
		push_sample(255, 255);
	endtask

	// Oversize source registers saturate to the store size.
	task automatic test_saturated_source();
		set_geometry(511, 511, 511, 511);
		push_sample(255, 255);
		push_sample(0, 0);
		set_geometry(SRC_MAX, SRC_MAX, SRC_MAX, SRC_MAX);
		push_sample(255, 255);
		push_sample(128, 7);
	endtask

	// The receiver holds off for a long stretch while samples keep coming,
	// so the block fills and stalls its input; then everything drains.
	task automatic test_backpressure();
		pace_on = 1'b0;
		set_geometry(6, 6, 4, 4);
		hold_off_len = 400;
		repeat (40)
			push_sample($urandom_range(0, 3), $urandom_range(0, 3));
		go_quiet();
	endtask

	// Random geometries, each followed by a stream of mostly well-formed
	// samples and loads with some out-of-range noise.
	task automatic test_random_traffic();
		int          phase_end;
		int unsigned r;
		int unsigned cmax;
		int unsigned rmax;
		for (int p = 0; p < PHASES; p++) begin
			set_geometry(pick_size(), pick_size(), pick_size(), pick_size());
			pace_on    = ($urandom_range(0, 9) < 7);
			burst_left = $urandom_range(1, 24);
			phase_end  = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					cmax = (dst_w == 0) ? 255 : clamp_size(dst_w, SRC_MAX) - 1;
					rmax = (dst_h == 0) ? 255 : clamp_size(dst_h, SRC_MAX) - 1;
					push_sample($urandom_range(0, cmax), $urandom_range(0, rmax));
				end else if (r < 85) begin
					cmax = (src_w == 0) ? 0 : clamp_size(src_w, SRC_MAX) - 1;
					rmax = (src_h == 0) ? 0 : clamp_size(src_h, SRC_MAX) - 1;
					push_load($urandom_range(0, cmax), $urandom_range(0, rmax),
						$urandom_range(0, 255));
				end else if (r < 95) begin
					push_sample($urandom_range(0, 255), $urandom_range(0, 255));
				end else begin
					push_load($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255));
				end
			end
		end
		pace_on = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_edge_clamping();
		test_fractional_step();
		test_zero_source();
		test_zero_destination();
		test_saturated_source();
		test_backpressure();
		test_random_traffic();
		go_quiet();
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
